@@ rtl/rcadc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC charge-time ADC scanner package
// Shared constants, scan state and result types.
// ----------------------------------------------------------------------------
package rcadc_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int PIN_BITS     = 8;
   localparam int CH_LIMIT     = (MAX_CHANNELS < PIN_BITS) ? MAX_CHANNELS : PIN_BITS;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 4;
   localparam int CHAN_W  = 3;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(CH_LIMIT);

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_DISCHARGE = 2'd1,
      PH_CHARGE    = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [CHAN_W-1:0]  channel_index;
      logic [TIME_W-1:0]  start_time;
      logic               discharge_on;
   } scan_state_type;

   typedef struct packed {
      logic               discharge_drive;
      logic               reading_valid;
      logic [CHAN_W-1:0]  reading_channel;
      logic [TIME_W-1:0]  reading_value;
      logic               ready_res;
   } scan_result_type;

   function automatic logic [COUNT_W-1:0] channel_count(input logic [COUNT_W-1:0] active);
      logic [COUNT_W-1:0] n;
      n = active;
      if (n == '0) begin
         n = COUNT_W'(1);
      end
      if (n > COUNT_LIMIT) begin
         n = COUNT_LIMIT;
      end
      return n;
   endfunction

endpackage : rcadc_pkg
`default_nettype wire

@@ rtl/rcadc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC charge-time ADC scan step
// Next scan state and result for one tick of timestamp and pin levels.
// ----------------------------------------------------------------------------
module rcadc_step (
   input  rcadc_pkg::scan_state_type            state_cur,
   input  logic [rcadc_pkg::COUNT_W-1:0]        active_channels,
   input  logic [rcadc_pkg::TIME_W-1:0]         time_now,
   input  logic [rcadc_pkg::PIN_BITS-1:0]       pin_levels,
   output rcadc_pkg::scan_state_type            state_nxt,
   output rcadc_pkg::scan_result_type           result
);
   import rcadc_pkg::*;

   logic               level;
   logic [COUNT_W-1:0] next_count;
   logic [COUNT_W-1:0] count;

   assign level      = pin_levels[state_cur.channel_index];
   assign next_count = COUNT_W'(state_cur.channel_index) + COUNT_W'(1);
   assign count      = channel_count(active_channels);

   always_comb begin
      state_nxt              = state_cur;
      result.reading_valid   = 1'b0;
      result.reading_channel = '0;
      result.reading_value   = '0;
      unique case (state_cur.phase)
         PH_DISCHARGE: begin
            if (!level) begin
               state_nxt.discharge_on = 1'b0;
               state_nxt.start_time   = time_now;
               state_nxt.phase        = PH_CHARGE;
            end
         end
         PH_CHARGE: begin
            if (level) begin
               result.reading_valid   = 1'b1;
               result.reading_channel = state_cur.channel_index;
               result.reading_value   = time_now - state_cur.start_time;
               if (next_count >= count) begin
                  state_nxt.channel_index = '0;
                  state_nxt.phase         = PH_IDLE;
               end else begin
                  state_nxt.channel_index = next_count[CHAN_W-1:0];
                  state_nxt.discharge_on  = 1'b1;
                  state_nxt.phase         = PH_DISCHARGE;
               end
            end
         end
         default: begin
            state_nxt.discharge_on = 1'b1;
            state_nxt.phase        = PH_DISCHARGE;
         end
      endcase
      result.discharge_drive = state_nxt.discharge_on;
      result.ready_res       = (state_nxt.phase == PH_IDLE);
   end

endmodule : rcadc_step
`default_nettype wire

@@ rtl/rc_charge_time_adc_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RC charge-time ADC scanner
// Scans comparator channels, timing each capacitor charge after a discharge.
// ----------------------------------------------------------------------------
// Each accepted tick's result is registered in the output register, or in the
// skid stage while the output is held. Throughput is one tick per cycle while
// the skid stage is empty, limited by the single scan-state register. The
// two-entry output register and skid stage keep the input open while a result
// waits. Synchronous reset returns the scan to idle on channel zero, drive released, channel count eight.
module rc_charge_time_adc_scanner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rcadc_pkg::COUNT_W-1:0]      csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // time_now [31:0], pin_levels [39:32].
   input  logic [rcadc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // discharge_drive [0], reading_channel [3:1], reading_value [35:4],
   // ready_res [36], zero [39:37].
   output logic [rcadc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // reading_valid [0].
   output logic                               rsp_tuser
);
   import rcadc_pkg::*;

   logic [COUNT_W-1:0] active_ff;
   scan_state_type     state_ff;
   scan_state_type     state_in;
   scan_result_type    result_in;
   scan_result_type    out_ff;
   scan_result_type    skid_ff;
   logic               out_valid_ff;
   logic               skid_valid_ff;
   logic               req_xfer;
   logic               out_free;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = rsp_tready || !out_valid_ff;

   rcadc_step u_step (
      .state_cur       (state_ff),
      .active_channels (active_ff),
      .time_now        (req_tdata[TIME_W-1:0]),
      .pin_levels      (req_tdata[TIME_W +: PIN_BITS]),
      .state_nxt       (state_in),
      .result          (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff              <= COUNT_RESET;
         state_ff.phase         <= PH_IDLE;
         state_ff.channel_index <= '0;
         state_ff.start_time    <= '0;
         state_ff.discharge_on  <= 1'b0;
         out_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_xfer;
            end
         end else if (req_xfer) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_xfer) begin
            out_ff <= result_in;
         end
      end else if (req_xfer) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.reading_valid;
   assign rsp_tdata  = {3'b000, out_ff.ready_res, out_ff.reading_value,
                        out_ff.reading_channel, out_ff.discharge_drive};

endmodule : rc_charge_time_adc_scanner
`default_nettype wire

@@ tb/sv/rcadc_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC charge-time ADC scanner checker
// Watches the tick, result and register channels and keeps its own copy of
// the scan state. Every accepted tick yields one predicted result, and each
// accepted result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rcadc_scan_checker
   import rcadc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [COUNT_W-1:0]     csr_wr_data,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tuser,
   output int                     mismatch_count,
   output int                     pending_count
);

   phase_type           scan_phase;
   logic [CHAN_W-1:0]   scan_channel;
   logic [TIME_W-1:0]   charge_start;
   logic                drive_on;
   logic [COUNT_W-1:0]  channel_setting;
   scan_result_type     expected_readings[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [COUNT_W-1:0] round_length(input logic [COUNT_W-1:0] setting);
      if (setting == '0) begin
         return COUNT_W'(1);
      end
      if (setting > COUNT_W'(CH_LIMIT)) begin
         return COUNT_W'(CH_LIMIT);
      end
      return setting;
   endfunction

   task automatic advance_scan(input logic [TIME_W-1:0] now, input logic [7:0] pins,
                               output scan_result_type res);
      logic level;
      level = pins[scan_channel];
      res   = '0;
      case (scan_phase)
         PH_DISCHARGE: begin
            if (!level) begin
               drive_on     = 1'b0;
               charge_start = now;
               scan_phase   = PH_CHARGE;
            end
         end
         PH_CHARGE: begin
            if (level) begin
               res.reading_valid   = 1'b1;
               res.reading_channel = scan_channel;
               res.reading_value   = now - charge_start;
               if ({1'b0, scan_channel} + COUNT_W'(1) >= round_length(channel_setting)) begin
                  scan_channel = '0;
                  scan_phase   = PH_IDLE;
               end else begin
                  scan_channel = scan_channel + CHAN_W'(1);
                  drive_on     = 1'b1;
                  scan_phase   = PH_DISCHARGE;
               end
            end
         end
         default: begin
            drive_on   = 1'b1;
            scan_phase = PH_DISCHARGE;
         end
      endcase
      res.discharge_drive = drive_on;
      res.ready_res       = (scan_phase == PH_IDLE);
   endtask

   task automatic note_mismatch(input string msg);
      if (mismatch_count < 10) begin
         $display("%0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      scan_result_type want;
      scan_result_type seen;
      if (reset) begin
         scan_phase      = PH_IDLE;
         scan_channel    = '0;
         charge_start    = '0;
         drive_on        = 1'b0;
         channel_setting = COUNT_W'(8);
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.discharge_drive = rsp_tdata[0];
            seen.reading_channel = rsp_tdata[3:1];
            seen.reading_value   = rsp_tdata[35:4];
            seen.ready_res       = rsp_tdata[36];
            seen.reading_valid   = rsp_tuser;
            if (expected_readings.size() == 0) begin
               note_mismatch($sformatf("unexpected result transfer, data %h", rsp_tdata));
            end else begin
               want = expected_readings.pop_front();
               if (seen.discharge_drive !== want.discharge_drive) begin
                  note_mismatch($sformatf("discharge_drive expected %0d, got %0d",
                                          want.discharge_drive, seen.discharge_drive));
               end
               if (seen.reading_valid !== want.reading_valid) begin
                  note_mismatch($sformatf("reading_valid expected %0d, got %0d",
                                          want.reading_valid, seen.reading_valid));
               end
               if (seen.reading_channel !== want.reading_channel) begin
                  note_mismatch($sformatf("reading_channel expected %0d, got %0d",
                                          want.reading_channel, seen.reading_channel));
               end
               if (seen.reading_value !== want.reading_value) begin
                  note_mismatch($sformatf("reading_value expected %h, got %h",
                                          want.reading_value, seen.reading_value));
               end
               if (seen.ready_res !== want.ready_res) begin
                  note_mismatch($sformatf("ready_res expected %0d, got %0d",
                                          want.ready_res, seen.ready_res));
               end
            end
            if (rsp_tdata[39:37] !== 3'b000) begin
               note_mismatch($sformatf("padding bits expected 0, got %b", rsp_tdata[39:37]));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_scan(req_tdata[31:0], req_tdata[39:32], want);
            expected_readings.push_back(want);
         end
         if (csr_wr_en) begin
            channel_setting = csr_wr_data;
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC charge-time ADC scanner testbench
// Drives timestamped comparator ticks through a directed opening and then
// random rounds under several channel counts, with random gaps and stalls on
// both sides and long receiver hold-offs. A separate checker predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import rcadc_pkg::*;

   localparam logic [COUNT_W-1:0] CHANNEL_SETTINGS [10] =
      '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd9, 4'd2, 4'd7, 4'd5, 4'd12};

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [COUNT_W-1:0]     csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   int                     mismatch_count;
   int                     pending_count;
   logic                   steady;
   logic [TIME_W-1:0]      tick_time;

   rc_charge_time_adc_scanner i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   rcadc_scan_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

   function automatic int pause_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   task automatic send_tick(input logic [TIME_W-1:0] now, input logic [7:0] pins);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {pins, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_channels(input logic [COUNT_W-1:0] setting);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_tick();
      int r;
      logic [7:0] pins;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         tick_time = tick_time + $urandom_range(0, 40);
      end else if (r < 95) begin
         tick_time = tick_time + $urandom_range(41, 200000);
      end else begin
         tick_time = $urandom();
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
         pins = 8'h00;
      end else if (r < 70) begin
         pins = 8'hFF;
      end else begin
         pins = 8'($urandom_range(0, 255));
      end
      send_tick(tick_time, pins);
      rest(pause_cycles());
   endtask

   initial begin : receiver
      int cycle_count;
      int hold_left;
      int wait_left;
      rsp_tready  = 1'b0;
      cycle_count = 0;
      hold_left   = 0;
      wait_left   = 0;
      forever begin
         @(negedge clock);
         cycle_count++;
         // Long hold-off so the output buffer fills and the tick input stalls.
         if (cycle_count % 1500 == 700) begin
            hold_left = 150;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (wait_left > 0) begin
            rsp_tready <= 1'b0;
            wait_left--;
         end else begin
            rsp_tready <= 1'b1;
            wait_left = pause_cycles();
         end
      end
   end

   initial begin : stimulus
      int seg;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      steady      = 1'b1;
      tick_time   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_channels(COUNT_W'(8));
      // Full scan start, a reading that wraps past 2^32 and a zero-length one.
      send_tick(32'h0000_0000, 8'hFF);
      send_tick(32'h0000_0001, 8'hFF);
      send_tick(32'hFFFF_FFF0, 8'h00);
      send_tick(32'hFFFF_FFFF, 8'hFE);
      send_tick(32'h0000_0005, 8'h01);
      send_tick(32'h0000_0006, 8'h00);
      send_tick(32'h0000_0006, 8'h02);
      send_tick(32'h0000_0007, 8'hFD);
      send_tick(32'h0000_0008, 8'h00);
      send_tick(32'h0000_0000, 8'h04);
      // Lower the channel count mid-round: channel three ends the round.
      settle();
      write_channels(COUNT_W'(2));
      send_tick(32'h0000_0009, 8'h00);
      send_tick(32'hFFFF_FFFF, 8'hFF);
      send_tick(32'h0000_000A, 8'h55);
      send_tick(32'h8000_0000, 8'hAA);

      for (seg = 0; seg < 10; seg++) begin
         settle();
         write_channels(CHANNEL_SETTINGS[seg]);
         steady <= (seg % 3 == 2);
         repeat (100) random_tick();
      end
      settle();
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
